// ===== hdl/ssr_pkg.sv =====
// ---------------------------------------------------------------------------
// ssr_pkg: shared types and constants for the stream substring replacer
// Pattern and replacement sizes, register indexes and the command and
// status bundles that join the controller and the datapath.
// ---------------------------------------------------------------------------
package ssr_pkg;

   localparam int PATTERN_MAX     = 8;
   localparam int REPLACEMENT_MAX = 8;
   localparam int EMIT_MAX        = (PATTERN_MAX > REPLACEMENT_MAX) ?
                                    PATTERN_MAX : REPLACEMENT_MAX;

   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 4;
   localparam int PATTERN_W   = BYTE_W * PATTERN_MAX;
   localparam int REPL_W      = BYTE_W * REPLACEMENT_MAX;
   localparam int BUF_IDX_W   = $clog2(PATTERN_MAX);
   localparam int IDX_W       = $clog2(EMIT_MAX);
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH     = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_BYTES      = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACEMENT_LENGTH = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACEMENT_BYTES  = CSR_INDEX_W'(3);

   // effective configuration, lengths already clamped to their legal range
   typedef struct packed {
      logic [LEN_W-1:0]     pattern_length;
      logic [PATTERN_W-1:0] pattern_bytes;
      logic [LEN_W-1:0]     replacement_length;
      logic [REPL_W-1:0]    replacement_bytes;
   } ssr_cfg_type;

   typedef struct packed {
      logic take;
      logic plan;
      logic emit;
      logic mark;
   } ssr_cmd_type;

   typedef struct packed {
      logic out_free;
      logic plan_empty;
      logic plan_last;
      logic emit_final;
   } ssr_stat_type;

endpackage

// ===== hdl/ssr_regs.sv =====
// ---------------------------------------------------------------------------
// ssr_regs: configuration registers
// Holds pattern and replacement settings and clamps both lengths.
// ---------------------------------------------------------------------------
module ssr_regs (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [ssr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ssr_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output ssr_pkg::ssr_cfg_type               cfg
);
   import ssr_pkg::*;

   logic [LEN_W-1:0]     pattern_length_ff, pattern_length_in;
   logic [PATTERN_W-1:0] pattern_bytes_ff, pattern_bytes_in;
   logic [LEN_W-1:0]     replacement_length_ff, replacement_length_in;
   logic [REPL_W-1:0]    replacement_bytes_ff, replacement_bytes_in;

   always_comb begin
      pattern_length_in     = pattern_length_ff;
      pattern_bytes_in      = pattern_bytes_ff;
      replacement_length_in = replacement_length_ff;
      replacement_bytes_in  = replacement_bytes_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PATTERN_LENGTH:     pattern_length_in     = csr_wdata[LEN_W-1:0];
            CSR_PATTERN_BYTES:      pattern_bytes_in      = csr_wdata[PATTERN_W-1:0];
            CSR_REPLACEMENT_LENGTH: replacement_length_in = csr_wdata[LEN_W-1:0];
            CSR_REPLACEMENT_BYTES:  replacement_bytes_in  = csr_wdata[REPL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff     <= LEN_W'(1);
         pattern_bytes_ff      <= '0;
         replacement_length_ff <= '0;
         replacement_bytes_ff  <= '0;
      end else begin
         pattern_length_ff     <= pattern_length_in;
         pattern_bytes_ff      <= pattern_bytes_in;
         replacement_length_ff <= replacement_length_in;
         replacement_bytes_ff  <= replacement_bytes_in;
      end
   end

   // empty pattern counts as one byte, oversize lengths saturate
   always_comb begin
      if (pattern_length_ff == '0) begin
         cfg.pattern_length = LEN_W'(1);
      end else if (pattern_length_ff > LEN_W'(PATTERN_MAX)) begin
         cfg.pattern_length = LEN_W'(PATTERN_MAX);
      end else begin
         cfg.pattern_length = pattern_length_ff;
      end
      if (replacement_length_ff > LEN_W'(REPLACEMENT_MAX)) begin
         cfg.replacement_length = LEN_W'(REPLACEMENT_MAX);
      end else begin
         cfg.replacement_length = replacement_length_ff;
      end
      cfg.pattern_bytes     = pattern_bytes_ff;
      cfg.replacement_bytes = replacement_bytes_ff;
   end

endmodule

// ===== hdl/ssr_ctrl.sv =====
// ---------------------------------------------------------------------------
// ssr_ctrl: sequencing controller
// Takes one item, has the datapath plan its results, then steps the
// emission into the output register as it frees up.
// ---------------------------------------------------------------------------
module ssr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ssr_pkg::ssr_stat_type stat,
   output ssr_pkg::ssr_cmd_type  cmd
);
   import ssr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PLAN,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   always_comb begin
      cmd.take = ready_ff && req_valid;
      cmd.plan = (state_ff == ST_PLAN);
      cmd.emit = (state_ff == ST_EMIT) && !stat.plan_empty && stat.out_free;
      cmd.mark = (state_ff == ST_EMIT) && stat.plan_empty && stat.plan_last &&
                 stat.out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.take) state_in = ST_PLAN;
         end
         ST_PLAN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.plan_empty) begin
               // bare end marker still has to get into the output register
               if (!stat.plan_last || stat.out_free) state_in = ST_IDLE;
            end else if (stat.out_free && stat.emit_final) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == ST_IDLE);
      end
   end

   assign req_ready = ready_ff;

endmodule

// ===== hdl/ssr_dp.sv =====
// ---------------------------------------------------------------------------
// ssr_dp: match datapath
// Holds the partial-match bytes as a shift line, plans each item's results
// and drives the registered result channel.
// ---------------------------------------------------------------------------
module ssr_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  ssr_pkg::ssr_cmd_type        cmd,
   output ssr_pkg::ssr_stat_type       stat,
   input  ssr_pkg::ssr_cfg_type        cfg,
   input  logic [ssr_pkg::BYTE_W-1:0]  req_in_byte,
   input  logic                        req_in_last,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic [ssr_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                        rsp_out_has_byte,
   output logic                        rsp_out_last
);
   import ssr_pkg::*;

   logic [BYTE_W-1:0] buf_ff [PATTERN_MAX];
   logic [BYTE_W-1:0] buf_in [PATTERN_MAX];
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic              last_ff, last_in;
   logic              match_ff, match_in;
   logic [LEN_W-1:0]  nemit_ff, nemit_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_has_ff, rsp_has_in;
   logic              rsp_last_ff, rsp_last_in;

   logic                   eq [PATTERN_MAX][PATTERN_MAX];
   logic [PATTERN_MAX-1:0] pre_ok;
   logic [PATTERN_MAX-1:0] cand;
   logic                   matched;
   logic [LEN_W-1:0]       shift;
   logic [LEN_W-1:0]       nemit_calc;
   logic [BYTE_W-1:0]      emit_byte;
   logic                   emit_final;

   // eq[s][i]: held byte s+i equals pattern byte i
   always_comb begin
      for (int s = 0; s < PATTERN_MAX; s++) begin
         for (int i = 0; i < PATTERN_MAX; i++) begin
            if (s + i < PATTERN_MAX) begin
               eq[s][i] = (buf_ff[BUF_IDX_W'(s + i)] ==
                           cfg.pattern_bytes[BYTE_W*i +: BYTE_W]);
            end else begin
               eq[s][i] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      for (int s = 0; s < PATTERN_MAX; s++) begin
         pre_ok[s] = 1'b1;
         for (int i = 0; i < PATTERN_MAX; i++) begin
            if (s + i < int'(cnt_ff)) pre_ok[s] = pre_ok[s] & eq[s][i];
         end
         // a kept tail must be a proper prefix, shorter than the pattern
         cand[s] = (s < int'(cnt_ff)) &&
                   (int'(cnt_ff) - s < int'(cfg.pattern_length)) && pre_ok[s];
      end
      matched = (cnt_ff == cfg.pattern_length) && pre_ok[0];
      shift = cnt_ff;
      for (int s = PATTERN_MAX - 1; s >= 0; s--) begin
         if (cand[s]) shift = LEN_W'(s);
      end
      if (matched) begin
         nemit_calc = cfg.replacement_length;
      end else if (last_ff) begin
         nemit_calc = cnt_ff;
      end else begin
         nemit_calc = shift;
      end
   end

   assign emit_byte  = match_ff ? cfg.replacement_bytes[{idx_ff, 3'b000} +: BYTE_W]
                                : buf_ff[0];
   assign emit_final = (LEN_W'(idx_ff) == nemit_ff - LEN_W'(1));

   // released bytes leave from the front, so the line shifts by one per pop
   always_comb begin
      buf_in = buf_ff;
      if (cmd.take) begin
         buf_in[cnt_ff[BUF_IDX_W-1:0]] = req_in_byte;
      end else if (cmd.emit && !match_ff) begin
         for (int i = 0; i < PATTERN_MAX - 1; i++) buf_in[i] = buf_ff[i + 1];
      end
   end

   always_comb begin
      cnt_in   = cnt_ff;
      last_in  = last_ff;
      match_in = match_ff;
      nemit_in = nemit_ff;
      idx_in   = idx_ff;
      if (cmd.take) begin
         cnt_in  = cnt_ff + LEN_W'(1);
         last_in = req_in_last;
      end
      if (cmd.plan) begin
         match_in = matched;
         nemit_in = nemit_calc;
         idx_in   = '0;
         if (matched) cnt_in = '0;
      end
      if (cmd.emit) begin
         idx_in = idx_ff + IDX_W'(1);
         if (!match_ff) cnt_in = cnt_ff - LEN_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_has_in   = rsp_has_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = emit_byte;
         rsp_has_in   = 1'b1;
         rsp_last_in  = last_ff && emit_final;
      end else if (cmd.mark) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = '0;
         rsp_has_in   = 1'b0;
         rsp_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff      <= buf_in;
      last_ff     <= last_in;
      match_ff    <= match_in;
      nemit_ff    <= nemit_in;
      idx_ff      <= idx_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_has_ff  <= rsp_has_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      stat.out_free   = !rsp_valid_ff || rsp_ready;
      stat.plan_empty = (nemit_ff == '0);
      stat.plan_last  = last_ff;
      stat.emit_final = emit_final;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = rsp_byte_ff;
   assign rsp_out_has_byte = rsp_has_ff;
   assign rsp_out_last     = rsp_last_ff;

`ifndef SYNTHESIS
   a_load_only_when_free : assert property (@(posedge clock) disable iff (reset)
      (cmd.emit || cmd.mark) |-> stat.out_free)
      else $error("output register loaded while occupied");

   a_held_in_range : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= LEN_W'(PATTERN_MAX))
      else $error("held byte count out of range");

   a_last_empties : assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && emit_final && last_ff) |=> (cnt_ff == '0))
      else $error("held bytes left after end of text");

   a_match_plan : assert property (@(posedge clock) disable iff (reset)
      (cmd.plan && matched) |=> (cnt_ff == '0 && nemit_ff == cfg.replacement_length))
      else $error("match did not clear held bytes or plan the replacement");
`endif

endmodule

// ===== hdl/stream_substring_replace.sv =====
// ---------------------------------------------------------------------------
// stream_substring_replace: streaming find and replace
// Replaces every leftmost non-overlapping occurrence of a pattern in a
// byte stream with a replacement string.
// ---------------------------------------------------------------------------
// Usage: text bytes enter on the req_ channel (valid/ready), one byte per
// item with req_in_last on the final byte. Results leave on the rsp_ channel
// one byte per item; rsp_out_has_byte low marks a bare end marker and
// rsp_out_last flags the final result of each text. The user must set
// pattern and replacement through the csr_ write port while the block is
// idle; the block itself does not enforce this. After acceptance an item
// passes through the plan state and then the emit state; each item releases
// up to 8 replaced or released bytes as results, and the emit sequencer puts
// one result per cycle into the single output register while it is free.
// A stalled receiver holds that register and the sequencer waits on it;
// req_ready stays low until the current item's results are all loaded.
// Reset (synchronous) empties the partial-match store, drops any pending
// result and restores pattern length 1, empty pattern and replacement.
// ---------------------------------------------------------------------------
module stream_substring_replace (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [ssr_pkg::BYTE_W-1:0]         req_in_byte,
   input  logic                               req_in_last,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ssr_pkg::BYTE_W-1:0]         rsp_out_byte,
   output logic                               rsp_out_has_byte,
   output logic                               rsp_out_last,
   input  logic                               csr_we,
   input  logic [ssr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ssr_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ssr_pkg::*;

   ssr_cfg_type  cfg;
   ssr_cmd_type  cmd;
   ssr_stat_type stat;

   ssr_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ssr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ssr_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .cfg              (cfg),
      .req_in_byte      (req_in_byte),
      .req_in_last      (req_in_last),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_has_byte (rsp_out_has_byte),
      .rsp_out_last     (rsp_out_last)
   );

endmodule
